@@ hdl/separable_covariance_kernel_unit_macros.svh @@
// Assertion shorthands; clock and reset are the block's own port names.
`ifndef SEPARABLE_COVARIANCE_KERNEL_UNIT_MACROS_SVH
`define SEPARABLE_COVARIANCE_KERNEL_UNIT_MACROS_SVH

`define SCKU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SCKU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/scku_pkg.sv @@
package scku_pkg;

   localparam int unsigned CORR_MAX_W = 25;

   typedef enum logic [1:0] {
      KIND_M52  = 2'd0,
      KIND_M32  = 2'd1,
      KIND_PEXP = 2'd2,
      KIND_ONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [31:0] distance;
      logic [31:0] inv_range;
      logic [17:0] roughness;
      logic        last_dim;
      kind_type    kind;
   } item_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  emit;
      logic [CORR_MAX_W-1:0] correlation;
   } seq_stat_type;

   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [63:0] ARG_LIMIT = 64'd32 << 30;
   localparam logic [63:0] W_LIMIT   = 64'd5 << 30;
   localparam logic [31:0] C_SQRT5   = 32'd2400959709;
   localparam logic [31:0] C_SQRT3   = 32'd1859775393;
   localparam logic [31:0] C_LOG2E   = 32'd1549082005;
   localparam logic [31:0] C_LN2     = 32'd744261118;
   localparam int unsigned ALPHA_FRAC = 16;

endpackage

@@ hdl/separable_covariance_kernel_unit.sv @@
// channel  dir  handshake              payload
// req      in   req_valid / req_stall  distance, inv_range, roughness, last_dim
// rsp      out  rsp_valid / rsp_stall  correlation
// csr      in   csr_valid / csr_ready  kernel_kind
//
// After the accepting edge the sequencer stays busy while it works on the beat, and on the
// last beat of an entry also while it waits to emit; its pace is set by the one shared 32x32
// multiplier, the twelve-step exponential series and, for power exponential, the leading-one
// walk and thirty squarings.
// Reset is synchronous; it clears the sequencer, the running product to 1.0,
// kernel_kind to Matern 5/2 and the result slot. A stalled result is held in
// its slot while the next beat is worked on; the last beat of an entry waits
// only if the slot is still full.
`include "separable_covariance_kernel_unit_macros.svh"

module separable_covariance_kernel_unit import scku_pkg::*; #(
   parameter int unsigned FRAC_BITS  = 16,
   parameter int unsigned DIST_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DIST_WIDTH-1:0] req_distance,
   input  logic [DIST_WIDTH-1:0] req_inv_range,
   input  logic [17:0]           req_roughness,
   input  logic                  req_last_dim,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [FRAC_BITS:0]    rsp_correlation,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_kernel_kind
);

   kind_type            kind_ff, kind_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAC_BITS:0]  rsp_corr_ff, rsp_corr_in;
   item_type            item;
   seq_stat_type        stat;
   mul_req_type         mul_req;
   logic [63:0]         mul_p;
   logic                start, slot_free;

   assign csr_ready = 1'b1;
   assign req_stall = stat.busy;
   assign start     = req_valid && !stat.busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign item.distance  = 32'(req_distance);
   assign item.inv_range = 32'(req_inv_range);
   assign item.roughness = req_roughness;
   assign item.last_dim  = req_last_dim;
   assign item.kind      = kind_ff;

   always_comb begin
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_corr_in  = rsp_corr_ff;
      if (csr_valid) begin
         kind_in = kind_type'(csr_kernel_kind);
      end
      if (stat.emit) begin
         rsp_valid_in = 1'b1;
         rsp_corr_in  = stat.correlation[FRAC_BITS:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_corr_ff <= rsp_corr_in;
      if (reset) begin
         kind_ff      <= KIND_M52;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = rsp_corr_ff;

   scku_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (mul_p)
   );

   scku_seq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .slot_free (slot_free),
      .stat      (stat),
      .mul_req   (mul_req),
      .mul_p     (mul_p)
   );

   `SCKU_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "sequencer not busy after accepting a beat")
   `SCKU_ASSERT_SAME(a_emit_into_free_slot, stat.emit, !rsp_valid_ff || !rsp_stall,
      "result written over a held beat")
   `SCKU_ASSERT_SAME(a_result_in_range, rsp_valid_ff,
      rsp_corr_ff <= {1'b1, {FRAC_BITS{1'b0}}}, "correlation above one")
   `SCKU_ASSERT_SAME(a_result_from_work, $rose(rsp_valid_ff), $past(stat.busy),
      "result appeared without a finished entry")

endmodule

@@ hdl/scku_mul.sv @@
module scku_mul import scku_pkg::*; (
   input  logic        clock,
   input  mul_req_type req,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;

   assign prod_in = 64'(req.a) * 64'(req.b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ hdl/scku_seq.sv @@
module scku_seq import scku_pkg::*; #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  item_type     item,
   input  logic         slot_free,
   output seq_stat_type stat,
   output mul_req_type  mul_req,
   input  logic [63:0]  mul_p
);

   localparam logic [63:0]        MAT_X_LIMIT = 64'd32 << FRAC_BITS;
   localparam logic [FRAC_BITS:0] ONE_F       = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [7:0]         FRAC_B8     = 8'(FRAC_BITS);

   typedef enum logic [5:0] {
      ST_IDLE, ST_X_ISSUE, ST_X_TAKE, ST_M_R, ST_M_P1, ST_M_P2, ST_M_P3, ST_M_P4,
      ST_M_P5, ST_EXP_T1, ST_EXP_T2, ST_EXP_T3, ST_EXP_Y, ST_ES_A, ST_ES_B, ST_ES_C,
      ST_EXP_FIN, ST_LZ, ST_LG_INIT, ST_SQ_A, ST_SQ_B, ST_LG_MAG, ST_LG_M1, ST_LG_M2,
      ST_LG_M3, ST_LG_W, ST_PE_Y, ST_PE_SHIFT, ST_PE_KDONE, ST_FOLD, ST_FOLD2, ST_EMIT
   } state_type;

   function automatic logic [31:0] recip(input logic [3:0] n);
      logic [31:0] v;
      begin
         unique case (n)
            4'd1:    v = 32'd4294967295;
            4'd2:    v = 32'd2147483647;
            4'd3:    v = 32'd1431655765;
            4'd4:    v = 32'd1073741823;
            4'd5:    v = 32'd858993459;
            4'd6:    v = 32'd715827882;
            4'd7:    v = 32'd613566756;
            4'd8:    v = 32'd536870911;
            4'd9:    v = 32'd477218588;
            4'd10:   v = 32'd429496729;
            4'd11:   v = 32'd390451572;
            4'd12:   v = 32'd357913941;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

   function automatic logic [31:0] div_fix(input logic [63:0] prod, input logic [31:0] num,
                                           input logic [3:0] n);
      logic [31:0] q0;
      logic [35:0] rem;
      begin
         q0  = prod[63:32];
         rem = 36'(num) - 36'(q0) * 36'(n);
         return (rem >= 36'(n)) ? q0 + 32'd1 : q0;
      end
   endfunction

   state_type           state_ff, state_in, ret_ff, ret_in, es_ret_ff, es_ret_in;
   item_type            item_ff, item_in;
   logic [FRAC_BITS:0]  rp_ff, rp_in, res_ff, res_in;
   logic [63:0]         r_ff, r_in, arg_ff, arg_in, t_ff, t_in, acc_ff, acc_in;
   logic [4:0]          kshift_ff, kshift_in, cnt_ff, cnt_in;
   logic [29:0]         y_ff, y_in, lf_ff, lf_in;
   logic [30:0]         p_ff, p_in, e_ff, e_in, kern_ff, kern_in, poly_ff, poly_in;
   logic [31:0]         m_ff, m_in;
   logic [3:0]          n_ff, n_in;
   logic [5:0]          pos_ff, pos_in;
   logic [37:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic signed [8:0]   s_ff, s_in;

   always_comb begin
      logic [63:0]        x, r, t, z, v, k;
      logic [31:0]        mm, q;
      logic [7:0]         pint;
      logic [37:0]        lg;
      logic [33:0]        whi;
      logic [29:0]        frac;
      logic signed [8:0]  wi, ns;
      state_in  = state_ff;   ret_in  = ret_ff;   es_ret_in = es_ret_ff;
      item_in   = item_ff;    rp_in   = rp_ff;    res_in    = res_ff;
      r_in      = r_ff;       arg_in  = arg_ff;   t_in      = t_ff;
      acc_in    = acc_ff;     kshift_in = kshift_ff; cnt_in = cnt_ff;
      y_in      = y_ff;       lf_in   = lf_ff;    p_in      = p_ff;
      e_in      = e_ff;       kern_in = kern_ff;  poly_in   = poly_ff;
      m_in      = m_ff;       n_in    = n_ff;     pos_in    = pos_ff;
      mag_in    = mag_ff;     neg_in  = neg_ff;   s_in      = s_ff;
      mul_req   = '0;
      x = mul_p >> FRAC_BITS;
      r = mul_p >> FRAC_BITS;
      t = mul_p + t_ff;
      z = {mul_p[33:0], 30'b0} + acc_ff;
      k = mul_p >> 20;
      mm = mul_p[61:30];
      q = div_fix(mul_p, m_ff, n_ff);
      pint = {2'b0, pos_ff} - FRAC_B8;
      lg = {pint, lf_ff};
      whi = acc_ff[63:30];
      frac = acc_ff[29:0];
      wi = neg_ff ? -($signed({2'b0, whi[6:0]}) + $signed({8'b0, (frac != 30'd0)}))
                  : $signed({2'b0, whi[6:0]});
      ns = -s_ff;
      v = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               state_in = ST_X_ISSUE;
            end
         end
         ST_X_ISSUE: begin
            mul_req.a = item_ff.distance;
            mul_req.b = item_ff.inv_range;
            state_in  = ST_X_TAKE;
         end
         ST_X_TAKE: begin
            unique case (item_ff.kind)
               KIND_M52, KIND_M32: begin
                  mul_req.a = x[31:0];
                  mul_req.b = (item_ff.kind == KIND_M52) ? C_SQRT5 : C_SQRT3;
                  if (x >= MAT_X_LIMIT) begin
                     kern_in  = '0;
                     state_in = ST_FOLD;
                  end else begin
                     state_in = ST_M_R;
                  end
               end
               KIND_PEXP: begin
                  if (item_ff.roughness == 18'd0) begin
                     arg_in   = 64'(Q30_ONE);
                     ret_in   = ST_PE_KDONE;
                     state_in = ST_EXP_T1;
                  end else if (x == 64'd0) begin
                     kern_in  = Q30_ONE;
                     state_in = ST_FOLD;
                  end else begin
                     acc_in   = x;
                     pos_in   = 6'd63;
                     state_in = ST_LZ;
                  end
               end
               KIND_ONE: begin
                  kern_in  = Q30_ONE;
                  state_in = ST_FOLD;
               end
            endcase
         end
         ST_M_R: begin
            if (r >= ARG_LIMIT) begin
               kern_in  = '0;
               state_in = ST_FOLD;
            end else begin
               r_in     = r;
               arg_in   = r;
               ret_in   = ST_M_P1;
               state_in = ST_EXP_T1;
            end
         end
         ST_EXP_T1: begin
            if (arg_ff >= ARG_LIMIT) begin
               e_in     = '0;
               state_in = ret_ff;
            end else begin
               mul_req.a = {2'b0, arg_ff[29:0]};
               mul_req.b = C_LOG2E;
               state_in  = ST_EXP_T2;
            end
         end
         ST_EXP_T2: begin
            t_in      = mul_p >> 30;
            mul_req.a = {27'b0, arg_ff[34:30]};
            mul_req.b = C_LOG2E;
            state_in  = ST_EXP_T3;
         end
         ST_EXP_T3: begin
            if (t[63:30] >= 34'd31) begin
               e_in     = '0;
               state_in = ret_ff;
            end else begin
               kshift_in = t[34:30];
               mul_req.a = {2'b0, t[29:0]};
               mul_req.b = C_LN2;
               state_in  = ST_EXP_Y;
            end
         end
         ST_EXP_Y: begin
            y_in      = mul_p[59:30];
            p_in      = Q30_ONE;
            n_in      = 4'd12;
            es_ret_in = ST_EXP_FIN;
            state_in  = ST_ES_A;
         end
         ST_ES_A: begin
            mul_req.a = {2'b0, y_ff};
            mul_req.b = {1'b0, p_ff};
            state_in  = ST_ES_B;
         end
         ST_ES_B: begin
            m_in      = mm;
            mul_req.a = mm;
            mul_req.b = recip(n_ff);
            state_in  = ST_ES_C;
         end
         ST_ES_C: begin
            p_in = Q30_ONE - q[30:0];
            if (n_ff == 4'd1) begin
               state_in = es_ret_ff;
            end else begin
               n_in     = n_ff - 4'd1;
               state_in = ST_ES_A;
            end
         end
         ST_EXP_FIN: begin
            e_in     = p_ff >> kshift_ff;
            state_in = ret_ff;
         end
         ST_M_P1: begin
            mul_req.a = {7'b0, r_ff[34:10]};
            mul_req.b = {7'b0, r_ff[34:10]};
            state_in  = ST_M_P2;
         end
         ST_M_P2: begin
            if (item_ff.kind == KIND_M52) begin
               m_in      = mul_p[51:20];
               n_in      = 4'd3;
               mul_req.a = mul_p[51:20];
               mul_req.b = recip(4'd3);
               state_in  = ST_M_P3;
            end else begin
               poly_in  = 31'h0010_0000 + 31'(r_ff[34:10]);
               state_in = ST_M_P4;
            end
         end
         ST_M_P3: begin
            poly_in  = 31'h0010_0000 + 31'(r_ff[34:10]) + q[30:0];
            state_in = ST_M_P4;
         end
         ST_M_P4: begin
            mul_req.a = {1'b0, poly_ff};
            mul_req.b = {1'b0, e_ff};
            state_in  = ST_M_P5;
         end
         ST_M_P5: begin
            kern_in  = (k > 64'(Q30_ONE)) ? Q30_ONE : k[30:0];
            state_in = ST_FOLD;
         end
         ST_LZ: begin
            if (acc_ff[63]) begin
               state_in = ST_LG_INIT;
            end else begin
               acc_in = {acc_ff[62:0], 1'b0};
               pos_in = pos_ff - 6'd1;
            end
         end
         ST_LG_INIT: begin
            m_in     = {1'b0, acc_ff[63:33]};
            lf_in    = '0;
            cnt_in   = 5'd30;
            state_in = ST_SQ_A;
         end
         ST_SQ_A: begin
            mul_req.a = m_ff;
            mul_req.b = m_ff;
            state_in  = ST_SQ_B;
         end
         ST_SQ_B: begin
            m_in   = mm[31] ? {1'b0, mm[31:1]} : mm;
            lf_in  = {lf_ff[28:0], mm[31]};
            cnt_in = cnt_ff - 5'd1;
            state_in = (cnt_ff == 5'd1) ? ST_LG_MAG : ST_SQ_A;
         end
         ST_LG_MAG: begin
            neg_in   = pint[7];
            mag_in   = pint[7] ? -lg : lg;
            state_in = ST_LG_M1;
         end
         ST_LG_M1: begin
            mul_req.a = {2'b0, mag_ff[29:0]};
            mul_req.b = {14'b0, item_ff.roughness};
            state_in  = ST_LG_M2;
         end
         ST_LG_M2: begin
            acc_in    = mul_p;
            mul_req.a = {24'b0, mag_ff[37:30]};
            mul_req.b = {14'b0, item_ff.roughness};
            state_in  = ST_LG_M3;
         end
         ST_LG_M3: begin
            acc_in   = z >> ALPHA_FRAC;
            state_in = ST_LG_W;
         end
         ST_LG_W: begin
            if (!neg_ff && acc_ff >= W_LIMIT) begin
               kern_in  = '0;
               state_in = ST_FOLD;
            end else if (frac == 30'd0) begin
               p_in     = Q30_ONE;
               s_in     = wi;
               state_in = ST_PE_SHIFT;
            end else begin
               s_in      = wi + 9'sd1;
               mul_req.a = neg_ff ? {2'b0, frac} : 32'(Q30_ONE - {1'b0, frac});
               mul_req.b = C_LN2;
               state_in  = ST_PE_Y;
            end
         end
         ST_PE_Y: begin
            y_in      = mul_p[59:30];
            p_in      = Q30_ONE;
            n_in      = 4'd12;
            es_ret_in = ST_PE_SHIFT;
            state_in  = ST_ES_A;
         end
         ST_PE_SHIFT: begin
            if (!s_ff[8]) begin
               v = 64'(p_ff) << s_ff[3:0];
            end else if (ns >= 9'sd63) begin
               v = '0;
            end else begin
               v = 64'(p_ff) >> ns[5:0];
            end
            arg_in   = v;
            ret_in   = ST_PE_KDONE;
            state_in = ST_EXP_T1;
         end
         ST_PE_KDONE: begin
            kern_in  = e_ff;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            mul_req.a = 32'(rp_ff);
            mul_req.b = {1'b0, kern_ff};
            state_in  = ST_FOLD2;
         end
         ST_FOLD2: begin
            if (item_ff.last_dim) begin
               res_in   = mul_p[30+FRAC_BITS:30];
               rp_in    = ONE_F;
               state_in = ST_EMIT;
            end else begin
               rp_in    = mul_p[30+FRAC_BITS:30];
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign stat.busy        = (state_ff != ST_IDLE);
   assign stat.emit        = (state_ff == ST_EMIT) && slot_free;
   assign stat.correlation = CORR_MAX_W'(res_ff);

   always_ff @(posedge clock) begin
      item_ff   <= item_in;   res_ff  <= res_in;   r_ff    <= r_in;
      arg_ff    <= arg_in;    t_ff    <= t_in;     acc_ff  <= acc_in;
      kshift_ff <= kshift_in; cnt_ff  <= cnt_in;   y_ff    <= y_in;
      lf_ff     <= lf_in;     p_ff    <= p_in;     e_ff    <= e_in;
      kern_ff   <= kern_in;   poly_ff <= poly_in;  m_ff    <= m_in;
      n_ff      <= n_in;      pos_ff  <= pos_in;   mag_ff  <= mag_in;
      neg_ff    <= neg_in;    s_ff    <= s_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         ret_ff    <= ST_IDLE;
         es_ret_ff <= ST_IDLE;
         rp_ff     <= ONE_F;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         es_ret_ff <= es_ret_in;
         rp_ff     <= rp_in;
      end
   end

endmodule
